>>> hw/rtl/wcd_pkg.sv
// Package for the weighted centroid distance unit: sizes, command codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
package wcd_pkg;
    localparam int MaxClusters = 8;
    localparam int MaxDims = 16;
    localparam int ClW = 3;
    localparam int DimW = 4;
    localparam int CentDepth = MaxClusters * MaxDims;
    localparam int CentAw = ClW + DimW;
    localparam int AccW = 48;
    localparam int DistW = 24;
    localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};
    localparam logic [15:0] WeightOne = 16'd4096;
    localparam int QDepth = 4;
    localparam int QPtrW = 2;

    typedef enum logic [1:0] {
        CMD_CENT  = 2'd0,
        CMD_WGT   = 2'd1,
        CMD_POINT = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic CFG_DIMS = 1'b0;
    localparam logic CFG_CLUSTERS = 1'b1;

    // work queued for the back end: one point coordinate
    typedef struct packed {
        logic [DimW-1:0] dim;
        logic [15:0]     coord;
        logic [15:0]     weight;
        logic            acc_en;
        logic            emit;
        logic [ClW:0]    nc;
    } job_t;
endpackage

>>> hw/rtl/wcd_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module wcd_ram #(
    parameter int Width = 16,
    parameter int Depth = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/wcd_front.sv
// Front end: accepts items, holds config and weights, writes centroids, queues point work.
// Depends on wcd_pkg.
`timescale 1ns / 1ps
module wcd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [1:0]            cmd,
    input  logic [2:0]            cl_idx,
    input  logic [3:0]            dim_idx,
    input  logic [15:0]           coord,
    input  logic [15:0]           wgt,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [4:0]            cfg_data,
    input  logic                  back_idle,
    output logic                  cent_we,
    output logic [wcd_pkg::CentAw-1:0] cent_waddr,
    output logic [15:0]           cent_wdata,
    output logic                  q_valid,
    input  logic                  q_ready,
    output wcd_pkg::job_t         q_job
);
    import wcd_pkg::*;

    logic [4:0]  dims_reg;
    logic [3:0]  clus_reg;
    logic [15:0] wtab_reg [MaxDims];
    job_t        q_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPtrW:0]   cnt_reg;
    logic [4:0]  nd;
    logic [ClW:0] nc;
    logic        acc_s, push, pop;
    cmd_t        c;
    job_t        j;

    assign c = cmd_t'(cmd);
    assign cfg_ready = 1'b1;
    // hold a centroid write until no queued or running point can still read the store
    assign s_tready = (cnt_reg != QDepth[QPtrW:0])
                      && (c != CMD_CENT || (cnt_reg == '0 && back_idle));
    assign acc_s = s_tvalid && s_tready;

    always_comb begin
        nd = dims_reg;
        if (nd == 5'd0) nd = 5'd1;
        if (nd > 5'(MaxDims)) nd = 5'(MaxDims);
        nc = clus_reg;
        if (nc == 4'd0) nc = 4'd1;
        if (nc > 4'(MaxClusters)) nc = 4'(MaxClusters);
        j.dim = dim_idx;
        j.coord = coord;
        j.weight = wtab_reg[dim_idx];
        j.acc_en = (wtab_reg[dim_idx] != 16'd0);
        j.emit = ({1'b0, dim_idx} == nd - 5'd1);
        j.nc = nc;
    end

    assign push = acc_s && c == CMD_POINT && {1'b0, dim_idx} < nd;
    assign pop = q_valid && q_ready;
    assign q_valid = (cnt_reg != '0);
    assign q_job = q_reg[rd_ptr_reg];

    assign cent_we = acc_s && c == CMD_CENT;
    assign cent_waddr = {cl_idx, dim_idx};
    assign cent_wdata = coord;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg <= 5'd16;
            clus_reg <= 4'd8;
            for (int i = 0; i < MaxDims; i++) wtab_reg[i] <= WeightOne;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_DIMS) dims_reg <= cfg_data;
                else clus_reg <= cfg_data[3:0];
            end
            if (acc_s && c == CMD_WGT) wtab_reg[dim_idx] <= wgt;
            if (push) begin
                q_reg[wr_ptr_reg] <= j;
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QDepth[QPtrW:0]) else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> s_tready) else $error("push into full queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> !pop) else $error("pop from empty queue");
endmodule

>>> hw/rtl/wcd_back.sv
// Back end: per-cluster accumulate through a two-stage multiply pipe, then serial isqrt
// and emit. Depends on wcd_pkg and wcd_ram (centroid store).
`timescale 1ns / 1ps
module wcd_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  wcd_pkg::job_t         q_job,
    input  logic                  cent_we,
    input  logic [wcd_pkg::CentAw-1:0] cent_waddr,
    input  logic [15:0]           cent_wdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2:0]            m_cluster,
    output logic [23:0]           m_distance,
    output logic                  m_last
);
    import wcd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_MUL, S_SQ, S_ACC, S_SQRT, S_OUT
    } state_t;

    state_t        st_reg;
    job_t          job_reg;
    logic [ClW:0]  k_reg;
    logic [AccW-1:0] acc_reg [MaxClusters];
    logic [15:0]   cent_rd;
    logic [32:0]   prod_reg;
    logic [20:0]   scaled;
    logic [41:0]   sq_reg;
    logic [AccW-1:0] v_reg, res_reg, bit_reg;
    logic [ClW-1:0] kk;
    logic [16:0]   diff, mag;
    logic [AccW:0] sum;
    logic [AccW-1:0] acc_new;
    logic [AccW-1:0] trial;

    assign kk = k_reg[ClW-1:0];

    wcd_ram #(.Width(16), .Depth(CentDepth)) u_cent (
        .aclk(aclk), .we(cent_we), .waddr(cent_waddr), .wdata(cent_wdata),
        .raddr({kk, job_reg.dim}), .rdata(cent_rd)
    );

    always_comb begin
        diff = {job_reg.coord[15], job_reg.coord} - {cent_rd[15], cent_rd};
        mag = diff[16] ? 17'(-diff) : diff;
        scaled = prod_reg[32:12];
        sum = {1'b0, acc_reg[kk]} + {7'd0, sq_reg};
        acc_new = sum[AccW] ? AccMax : sum[AccW-1:0];
        trial = res_reg + bit_reg;
    end

    assign q_ready = (st_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            m_tvalid <= 1'b0;
            k_reg <= '0;
            for (int i = 0; i < MaxClusters; i++) acc_reg[i] <= '0;
        end else begin
            unique case (st_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        job_reg <= q_job;
                        k_reg <= '0;
                        if (q_job.acc_en) st_reg <= S_RD;
                        else if (q_job.emit) st_reg <= S_SQRT;
                    end
                end
                S_RD: st_reg <= S_MUL;
                S_MUL: begin
                    prod_reg <= {16'd0, mag} * {17'd0, job_reg.weight} + 33'd2048;
                    st_reg <= S_SQ;
                end
                S_SQ: begin
                    sq_reg <= {21'd0, scaled} * {21'd0, scaled};
                    st_reg <= S_ACC;
                end
                S_ACC: begin
                    acc_reg[kk] <= acc_new;
                    if (k_reg == job_reg.nc - 1'b1) begin
                        k_reg <= '0;
                        st_reg <= job_reg.emit ? S_SQRT : S_IDLE;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                        st_reg <= S_RD;
                    end
                end
                S_SQRT: begin
                    if (bit_reg == '0) begin
                        m_tvalid <= 1'b1;
                        m_cluster <= kk;
                        m_distance <= res_reg[DistW-1:0];
                        m_last <= (k_reg == job_reg.nc - 1'b1);
                        st_reg <= S_OUT;
                    end else begin
                        if (v_reg >= trial) begin
                            v_reg <= v_reg - trial;
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end else begin
                            res_reg <= res_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        m_tvalid <= 1'b0;
                        if (k_reg == job_reg.nc - 1'b1) begin
                            for (int i = 0; i < MaxClusters; i++) acc_reg[i] <= '0;
                            st_reg <= S_IDLE;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                            st_reg <= S_SQRT;
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
            if ((st_reg == S_IDLE && q_valid && !q_job.acc_en && q_job.emit)
                || (st_reg == S_ACC && job_reg.emit && k_reg == job_reg.nc - 1'b1)) begin
                v_reg <= (st_reg == S_ACC && kk == '0) ? acc_new : acc_reg[0];
                res_reg <= '0;
                bit_reg <= 48'h4000_0000_0000;
            end
            if (st_reg == S_OUT && m_tready && k_reg != job_reg.nc - 1'b1) begin
                v_reg <= acc_reg[kk + 1'b1];
                res_reg <= '0;
                bit_reg <= 48'h4000_0000_0000;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> st_reg == S_OUT) else $error("output valid outside emit");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != S_IDLE) |-> !q_ready) else $error("queue popped while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
endmodule

>>> hw/rtl/weighted_centroid_distance_unit.sv
// Top level of the weighted centroid distance unit.
// An accepted point coordinate is written into the front-end queue and popped when the back
// end is idle; the back end then reads, multiplies, squares and accumulates per cluster. The
// last dimension adds per cluster 24 isqrt steps, emit, output handshake, plus stalls.
// Coordinates queue up while the back end is busy; a centroid write waits for an empty
// queue and idle back end. Reset (aresetn low, sync) restores weights, 16 dims, 8 clusters.
`timescale 1ns / 1ps
module weighted_centroid_distance_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[1:0]
    input  logic [1:0]  s_tuser,
    // cluster_index[2:0], dim_index[6:3], coord_value[22:7], weight_value[38:23]
    input  logic [39:0] s_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cluster_id[2:0], distance[26:3]
    output logic [31:0] m_tdata,
    output logic        m_tlast
);
    import wcd_pkg::*;

    logic cent_we, q_valid, q_ready;
    logic [CentAw-1:0] cent_waddr;
    logic [15:0] cent_wdata;
    job_t q_job;
    logic [2:0] cl;
    logic [23:0] dist_val;

    wcd_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready,
        .cmd(s_tuser), .cl_idx(s_tdata[2:0]), .dim_idx(s_tdata[6:3]),
        .coord(s_tdata[22:7]), .wgt(s_tdata[38:23]),
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .back_idle(q_ready),
        .cent_we, .cent_waddr, .cent_wdata, .q_valid, .q_ready, .q_job
    );

    wcd_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_job,
        .cent_we, .cent_waddr, .cent_wdata,
        .m_tvalid, .m_tready, .m_cluster(cl), .m_distance(dist_val), .m_last(m_tlast)
    );

    assign m_tdata = {5'd0, dist_val, cl};
endmodule

>>> tb/weighted_centroid_distance_unit_tb.sv
// Testbench for weighted_centroid_distance_unit: directed and random point streams,
// checked against a behavioral predictor of weighted centroid distances.
// Depends on wcd_pkg and the RTL top level.
`timescale 1ns / 1ps
module weighted_centroid_distance_unit_tb;
    import wcd_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int LoadDims = 4;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [39:0] s_tdata = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [4:0]  cfg_data = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    typedef struct packed {
        logic [2:0]  cluster_id;
        logic [23:0] distance;
        logic        last_of_run;
    } dist_t;

    logic [15:0] centroid_mem [CentDepth];
    logic [15:0] weight_mem [MaxDims];
    logic [AccW-1:0] dist_acc [MaxClusters];
    logic [4:0]  dims_reg;
    logic [3:0]  clusters_reg;
    dist_t       expected_q[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;

    always #5 aclk = ~aclk;

    weighted_centroid_distance_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [23:0] root48(input logic [AccW-1:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = {16'd0, v};
        res = 64'd0;
        b = 64'd1 << 46;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res[23:0];
    endfunction

    function automatic int active_dims();
        if (dims_reg == 0) return 1;
        if (dims_reg > MaxDims) return MaxDims;
        return int'(dims_reg);
    endfunction

    function automatic int active_clusters();
        if (clusters_reg == 0) return 1;
        if (clusters_reg > MaxClusters) return MaxClusters;
        return int'(clusters_reg);
    endfunction

    task automatic predict_distances(input cmd_t cmd, input int cl, input int dim,
                                     input logic [15:0] coord, input logic [15:0] wgt);
        int nd;
        int nc;
        int diff;
        logic [63:0] mag;
        logic [63:0] scaled;
        logic [63:0] sq;
        dist_t r;
        nd = active_dims();
        nc = active_clusters();
        case (cmd)
            CMD_CENT: centroid_mem[cl * MaxDims + dim] = coord;
            CMD_WGT: weight_mem[dim] = wgt;
            CMD_POINT: begin
                if (dim < nd) begin
                    if (weight_mem[dim] != 0) begin
                        for (int k = 0; k < nc; k++) begin
                            diff = $signed(coord) - $signed(centroid_mem[k * MaxDims + dim]);
                            mag = 64'(diff < 0 ? -diff : diff);
                            scaled = (mag * 64'(weight_mem[dim]) + 64'd2048) >> 12;
                            sq = scaled * scaled;
                            if (sq > {16'd0, AccMax} - 64'(dist_acc[k])) dist_acc[k] = AccMax;
                            else dist_acc[k] = 48'(64'(dist_acc[k]) + sq);
                        end
                    end
                    if (dim == nd - 1) begin
                        for (int k = 0; k < nc; k++) begin
                            r.cluster_id = 3'(k);
                            r.distance = root48(dist_acc[k]);
                            r.last_of_run = (k == nc - 1);
                            expected_q.push_back(r);
                        end
                        for (int k = 0; k < MaxClusters; k++) dist_acc[k] = '0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input cmd_t cmd, input int cl, input int dim,
                             input logic [15:0] coord, input logic [15:0] wgt);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= 2'(cmd);
        s_tdata <= {1'b0, wgt, coord, 4'(dim), 3'(cl)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_distances(cmd, cl, dim, coord, wgt);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (4 * MaxClusters + 30 * MaxClusters) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [4:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_DIMS) dims_reg = val;
        else clusters_reg = val[3:0];
    endtask

    task automatic load_all_centroids(input bit extremes);
        for (int c = 0; c < MaxClusters; c++)
            for (int d = 0; d < LoadDims; d++)
                send_item(CMD_CENT, c, d,
                    extremes ? ((c + d) % 2 ? 16'h8000 : 16'h7fff) : 16'($urandom), 16'($urandom));
    endtask

    task automatic send_point(input int nd);
        for (int d = 0; d < nd; d++)
            send_item(CMD_POINT, $urandom_range(0, 7), d, 16'($urandom), 16'($urandom));
    endtask

    task automatic test_directed();
        load_all_centroids(1'b1);
        write_reg(CFG_DIMS, 5'd2);
        write_reg(CFG_CLUSTERS, 5'd8);
        send_item(CMD_POINT, 0, 0, 16'h8000, 0);
        send_item(CMD_POINT, 0, 1, 16'h7fff, 0);
        send_item(CMD_WGT, 0, 0, 0, 16'hffff);
        send_item(CMD_WGT, 0, 1, 0, 16'h0000);
        send_item(CMD_POINT, 0, 0, 16'h7fff, 0);
        send_item(CMD_POINT, 0, 0, 16'h7fff, 0);
        send_item(CMD_POINT, 0, 1, 16'h8000, 0);
        send_item(CMD_NONE, 7, 15, 16'hffff, 16'hffff);
        send_item(CMD_POINT, 7, 5, 16'h1234, 16'hffff);
        send_item(CMD_POINT, 0, 1, 16'h0000, 0);
        write_reg(CFG_DIMS, 5'd0);
        write_reg(CFG_CLUSTERS, 5'd0);
        send_item(CMD_POINT, 0, 0, 16'h0100, 0);
        write_reg(CFG_DIMS, 5'd31);
        write_reg(CFG_CLUSTERS, 5'd15);
        send_item(CMD_WGT, 0, MaxDims - 1, 0, 16'h0000);
        send_item(CMD_POINT, 0, MaxDims - 1, 16'h0100, 0);
        send_item(CMD_WGT, 0, 0, 0, WeightOne);
        send_item(CMD_WGT, 0, 1, 0, WeightOne);
    endtask

    task automatic test_random();
        int sent;
        int nd;
        sent = 0;
        write_reg(CFG_DIMS, 5'($urandom_range(1, LoadDims)));
        write_reg(CFG_CLUSTERS, 5'($urandom_range(1, 3)));
        while (sent < 64) begin
            if ($urandom_range(0, 9) == 0) begin
                write_reg(CFG_DIMS, 5'($urandom_range(1, LoadDims)));
                write_reg(CFG_CLUSTERS, 5'($urandom_range(1, 8)));
            end
            if ($urandom_range(0, 5) == 0) begin
                send_item(cmd_t'($urandom_range(0, 1)), $urandom_range(0, 7),
                          $urandom_range(0, 15), 16'($urandom), 16'($urandom_range(0, 3) == 0 ?
                          0 : $urandom));
                sent++;
            end else if ($urandom_range(0, 7) == 0) begin
                send_item(cmd_t'($urandom_range(2, 3)), $urandom_range(0, 7),
                          $urandom_range(0, 15), 16'($urandom), 16'($urandom));
                sent++;
            end else begin
                nd = active_dims();
                send_point(nd);
                sent += nd;
            end
            if ($urandom_range(0, 20) == 0) drain_results();
        end
    endtask

    initial begin
        for (int i = 0; i < MaxDims; i++) weight_mem[i] = WeightOne;
        for (int i = 0; i < MaxClusters; i++) dist_acc[i] = '0;
        dims_reg = 5'd16;
        clusters_reg = 4'd8;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        drain_results();
        if (error_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) m_tready <= ((cycle_count / 37) % 3 == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    always @(posedge aclk) begin
        dist_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report("unexpected item", m_tdata, 0);
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[2:0] != want.cluster_id)
                    report("cluster_id", m_tdata[2:0], want.cluster_id);
                if (m_tdata[26:3] != want.distance)
                    report("distance", m_tdata[26:3], want.distance);
                if (m_tlast != want.last_of_run)
                    report("last_of_run", m_tlast, want.last_of_run);
            end
        end
    end
endmodule

>>> files.f
hw/rtl/wcd_pkg.sv
hw/rtl/wcd_ram.sv
hw/rtl/wcd_front.sv
hw/rtl/wcd_back.sv
hw/rtl/weighted_centroid_distance_unit.sv
tb/weighted_centroid_distance_unit_tb.sv
